// File: src/gpnm_pkg.sv
// Shared types and constants of the gear position decoder.
// Holds command codes, register indexes, field widths and the search token.
// No dependencies; every other file in src uses it.
package gpnm_pkg;

  // Default sizes, handed to the top level parameters
  localparam int TableDepthDef = 8;
  localparam int AvgWindowDef  = 8;

  // Field widths fixed by the interface
  localparam int SampleW = 16;
  localparam int LabelW  = 8;
  localparam int IndexW  = 3;
  localparam int CmdW    = 2;
  localparam int CountW  = 4;
  localparam int TolW    = 16;
  localparam int AddrW   = 3;
  localparam int DataW   = 32;

  // Register reset values and special labels
  localparam logic [TolW-1:0]   TolReset = 16'd64;
  localparam logic [LabelW-1:0] NoGear   = 8'hFF;

  // Item commands
  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_CAPTURE = 2'd2
  } cmd_e;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_GEAR_COUNT = 1'b0,
    REG_MATCH_TOL  = 1'b1
  } reg_idx_e;

  // Token walking the row of table cells
  typedef struct packed {
    logic                valid;
    logic [SampleW-1:0]  avg;
    logic                wr_en;
    logic [IndexW-1:0]   wr_idx;
    logic [LabelW-1:0]   label;
    logic [SampleW-1:0]  wr_raw;
    logic                cap_en;
    logic                found;
    logic [SampleW-1:0]  best_dist;
    logic [LabelW-1:0]   best_label;
  } tok_t;

endpackage

// File: src/gpnm_window.sv
// Boxcar moving average: a shift line of samples, a running sum and a
// reciprocal multiply for the divide by window length. Uses gpnm_pkg.
module gpnm_window #(
  parameter int AVG_WINDOW = gpnm_pkg::AvgWindowDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [gpnm_pkg::SampleW-1:0] sample_i,
  output logic [gpnm_pkg::SampleW-1:0] avg_o
);

  localparam int LogW  = $clog2(AVG_WINDOW);
  localparam int SumW  = gpnm_pkg::SampleW + LogW;
  localparam int Shift = SumW + LogW;
  localparam int ProdW = 2 * SumW + 1;
  // ceil(2^Shift / AVG_WINDOW) gives an exact quotient for any SumW-bit sum
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW);
  localparam logic [SumW:0] Recip = RecipWide[SumW:0];

  logic [gpnm_pkg::SampleW-1:0] taps_q [AVG_WINDOW];
  logic [SumW-1:0]              sum_q, sum_d;
  logic [ProdW-1:0]             prod_q;

  // Drop the oldest tap, add the new sample
  assign sum_d = sum_q - SumW'(taps_q[AVG_WINDOW-1]) + SumW'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int j = 0; j < AVG_WINDOW; j++) begin
        taps_q[j] <= '0;
      end
    end else if (push_i) begin
      sum_q     <= sum_d;
      taps_q[0] <= sample_i;
      for (int j = 1; j < AVG_WINDOW; j++) begin
        taps_q[j] <= taps_q[j-1];
      end
    end
  end

  // Track the sum with a registered multiply by the reciprocal
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(sum_q) * ProdW'(Recip);
  end

  assign avg_o = prod_q[Shift +: gpnm_pkg::SampleW];

endmodule

// File: src/gpnm_cell.sv
// One table entry of the gear decoder and its step of the nearest search.
// Applies writes and captures to its entry, then passes the token on. Uses gpnm_pkg.
module gpnm_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gpnm_pkg::CountW-1:0] gear_count_i,
  input  gpnm_pkg::tok_t              tok_i,
  output gpnm_pkg::tok_t              tok_o
);

  logic [gpnm_pkg::LabelW-1:0]  label_q;
  logic [gpnm_pkg::SampleW-1:0] raw_q;
  logic                         in_use;
  logic                         hit_wr;
  logic                         hit_cap;
  logic [gpnm_pkg::SampleW-1:0] eff_raw;
  logic [gpnm_pkg::LabelW-1:0]  eff_label;
  logic [gpnm_pkg::SampleW-1:0] diff;
  logic                         better;
  gpnm_pkg::tok_t               tok_d, tok_q;

  assign in_use  = INDEX < int'(gear_count_i);
  assign hit_wr  = tok_i.valid && tok_i.wr_en && (int'(tok_i.wr_idx) == INDEX);
  assign hit_cap = tok_i.valid && tok_i.cap_en && in_use && (label_q == tok_i.label);

  // Compare against the entry as it stands after this beat's update
  always_comb begin
    eff_label = hit_wr ? tok_i.label : label_q;
    if (hit_wr) begin
      eff_raw = tok_i.wr_raw;
    end else if (hit_cap) begin
      eff_raw = tok_i.avg;
    end else begin
      eff_raw = raw_q;
    end
    diff   = (tok_i.avg > eff_raw) ? tok_i.avg - eff_raw : eff_raw - tok_i.avg;
    better = in_use && (!tok_i.found || (diff < tok_i.best_dist));

    tok_d = tok_i;
    if (hit_cap) begin
      tok_d.cap_en = 1'b0;
    end
    if (better) begin
      tok_d.found      = 1'b1;
      tok_d.best_dist  = diff;
      tok_d.best_label = eff_label;
    end
  end

  // Hold the entry; no reset, software writes it before use
  always_ff @(posedge clk_i) begin
    if (hit_wr) begin
      label_q <= tok_i.label;
    end
    if (hit_wr || hit_cap) begin
      raw_q <= eff_raw;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/gear_position_nearest_match.sv
// Gear position decoder: moving average of a sensor and nearest table match.
// Instantiates gpnm_window and a row of gpnm_cell; uses gpnm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per beat: a
//   sample (cmd 0) pushes raw_sample_i into the average, a write (cmd 1)
//   loads table slot entry_index_i, a capture (cmd 2) stores the current
//   average into the first in-use entry labelled entry_label_i.
//   Output channel (out_valid_o / out_stall_i) returns one beat per item:
//   the nearest in-use gear label (-1 when none lies within tolerance) and
//   the current average.
//   From input beat to output valid an item passes the sum register, the
//   reciprocal multiply register, one register per table cell the search
//   token passes, the result stage and the output register. Only one item
//   is in flight: in_stall_o stays high from the accepted beat until its
//   result is loaded into the output register.
//   A finished result waits in the output register while the next item is
//   taken; if the receiver still stalls when the next result is ready, the
//   block holds that result and keeps in_stall_o high.
//   Reset clears the window, the sum, gear_count (0) and match_tolerance
//   (64); table entries hold nothing defined until written.
//   Configuration is APB: gear_count at 0x0, match_tolerance at 0x4.
module gear_position_nearest_match #(
  parameter int TABLE_DEPTH = gpnm_pkg::TableDepthDef,
  parameter int AVG_WINDOW  = gpnm_pkg::AvgWindowDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gpnm_pkg::AddrW-1:0]         paddr,
  input  logic [gpnm_pkg::DataW-1:0]         pwdata,
  output logic [gpnm_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gpnm_pkg::CmdW-1:0]          cmd_i,
  input  logic [gpnm_pkg::SampleW-1:0]       raw_sample_i,
  input  logic [gpnm_pkg::IndexW-1:0]        entry_index_i,
  input  logic signed [gpnm_pkg::LabelW-1:0] entry_label_i,
  input  logic [gpnm_pkg::SampleW-1:0]       entry_raw_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [gpnm_pkg::LabelW-1:0] detected_gear_o,
  output logic [gpnm_pkg::SampleW-1:0]       average_value_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_AVG   = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [gpnm_pkg::CountW-1:0]   gear_count_q;
  logic [gpnm_pkg::TolW-1:0]     tol_q;
  logic                          cfg_wr;
  logic [gpnm_pkg::CountW-1:0]   count_wr;
  logic                          in_acc;
  logic                          push;
  logic [gpnm_pkg::CmdW-1:0]     cmd_q;
  logic [gpnm_pkg::IndexW-1:0]   idx_q;
  logic [gpnm_pkg::LabelW-1:0]   label_q;
  logic [gpnm_pkg::SampleW-1:0]  eraw_q;
  logic [gpnm_pkg::SampleW-1:0]  avg_w;
  gpnm_pkg::tok_t                tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]        tok_vld;
  gpnm_pkg::tok_t                tok_last;
  logic [gpnm_pkg::LabelW-1:0]   res_gear_q;
  logic [gpnm_pkg::SampleW-1:0]  res_avg_q;
  logic                          out_load;
  logic                          out_valid_q;
  logic [gpnm_pkg::LabelW-1:0]   gear_out_q;
  logic [gpnm_pkg::SampleW-1:0]  avg_out_q;

  // Configuration registers
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign count_wr = ({28'd0, pwdata[gpnm_pkg::CountW-1:0]} > 32'(TABLE_DEPTH))
                    ? gpnm_pkg::CountW'(TABLE_DEPTH)
                    : pwdata[gpnm_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_count_q <= '0;
      tol_q        <= gpnm_pkg::TolReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        gpnm_pkg::REG_GEAR_COUNT: gear_count_q <= count_wr;
        gpnm_pkg::REG_MATCH_TOL:  tol_q        <= pwdata[gpnm_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gpnm_pkg::REG_GEAR_COUNT: prdata = {28'd0, gear_count_q};
      gpnm_pkg::REG_MATCH_TOL:  prdata = {16'd0, tol_q};
      default:                  prdata = '0;
    endcase
  end

  // Input beat
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push       = in_acc && (cmd_i == gpnm_pkg::CMD_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      idx_q   <= entry_index_i;
      label_q <= entry_label_i;
      eraw_q  <= entry_raw_i;
    end
  end

  gpnm_window #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (raw_sample_i),
    .avg_o    (avg_w)
  );

  // Launch the search token once the average has settled
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = (state_q == ST_ISSUE);
    tok[0].avg        = avg_w;
    tok[0].wr_en      = (cmd_q == gpnm_pkg::CMD_WRITE);
    tok[0].wr_idx     = idx_q;
    tok[0].label      = label_q;
    tok[0].wr_raw     = eraw_q;
    tok[0].cap_en     = (cmd_q == gpnm_pkg::CMD_CAPTURE);
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    gpnm_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .gear_count_i (gear_count_q),
      .tok_i        (tok[i]),
      .tok_o        (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  assign tok_last = tok[TABLE_DEPTH];

  // Stage the result as the token leaves the row
  always_ff @(posedge clk_i) begin
    if (tok_last.valid) begin
      res_avg_q <= tok_last.avg;
      if (tok_last.found && ({16'd0, tok_last.best_dist} <= {16'd0, tol_q})) begin
        res_gear_q <= tok_last.best_label;
      end else begin
        res_gear_q <= gpnm_pkg::NoGear;
      end
    end
  end

  // Sequence one item through average, search and output
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_AVG;
      ST_AVG:   state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_RUN;
      ST_RUN:   if (tok_last.valid) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      gear_out_q <= res_gear_q;
      avg_out_q  <= res_avg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign detected_gear_o = gear_out_q;
  assign average_value_o = avg_out_q;

`ifndef SYNTHESIS
  // Only one token travels the row at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one search token in the cell row");

  // The token leaves the row only while the sequencer waits for it
  a_tok_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.valid |-> state_q == ST_RUN)
    else $error("search token finished outside the run state");

  // An accepted beat starts the average step
  a_acc_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_AVG)
    else $error("accepted beat did not start the average step");

  // A new result appears only after the output stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result shown without passing the output stage");
`endif

endmodule

// File: tb/sv/gear_position_nearest_match_test.sv
// Self-checking testbench for the gear position decoder (moving average plus nearest table match).
// Depends on gpnm_pkg and gear_position_nearest_match. Predicts each result beat itself and
// checks it against the beats that the block returns.
`timescale 1ns / 1ps

module gear_position_nearest_match_test;
  import gpnm_pkg::*;

  localparam int TableDepth    = TableDepthDef;
  localparam int AvgWin        = AvgWindowDef;
  localparam int SumW          = SampleW + $clog2(AvgWin);
  localparam int PhaseItems    = 240;
  localparam int RandomPhases  = 8;
  localparam int WatchdogLimit = 4000;
  localparam int MaxReports    = 10;
  localparam logic [CmdW-1:0] CmdReserved = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [SampleW-1:0]       raw_sample;
    logic [IndexW-1:0]        entry_index;
    logic signed [LabelW-1:0] entry_label;
    logic [SampleW-1:0]       entry_raw;
  } gear_item_t;

  typedef struct packed {
    logic signed [LabelW-1:0] gear;
    logic [SampleW-1:0]       average;
  } gear_reading_t;

  // Clock, reset and block ports; the driven inputs are known from time zero
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [AddrW-1:0]          paddr         = '0;
  logic [DataW-1:0]          pwdata        = '0;
  logic [DataW-1:0]          prdata;
  logic                      pready;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [CmdW-1:0]           cmd_i         = '0;
  logic [SampleW-1:0]        raw_sample_i  = '0;
  logic [IndexW-1:0]         entry_index_i = '0;
  logic signed [LabelW-1:0]  entry_label_i = '0;
  logic [SampleW-1:0]        entry_raw_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic signed [LabelW-1:0]  detected_gear_o;
  logic [SampleW-1:0]        average_value_o;

  // Predictor state: window, sum, slot, gear table and registers
  logic [SampleW-1:0]       win_samples [AvgWin];
  logic [SumW-1:0]          win_sum;
  int unsigned              win_slot;
  logic signed [LabelW-1:0] gear_labels [TableDepth];
  logic [SampleW-1:0]       gear_raws [TableDepth];
  int unsigned              gears_in_use;
  logic [TolW-1:0]          tolerance;

  gear_reading_t readings_due [$];
  gear_reading_t seen_reading;
  gear_reading_t due_reading;
  int            failure_count = 0;
  int            idle_cycles   = 0;
  int            burst_left    = 0;
  int            stall_mode    = 0;
  int            stall_run     = 0;
  int            drift_target  = 0;

  gear_position_nearest_match DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .raw_sample_i    (raw_sample_i),
    .entry_index_i   (entry_index_i),
    .entry_label_i   (entry_label_i),
    .entry_raw_i     (entry_raw_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .detected_gear_o (detected_gear_o),
    .average_value_o (average_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one item to the predictor and return the reading it should produce
  function automatic gear_reading_t predict_gear(gear_item_t it);
    gear_reading_t res;
    logic [SampleW-1:0] avg;
    int unsigned best_dist;
    int unsigned diff;
    bit hit;
    int i;
    hit = 1'b0;
    case (it.cmd)
      CMD_SAMPLE: begin
        win_sum = win_sum - SumW'(win_samples[win_slot]) + SumW'(it.raw_sample);
        win_samples[win_slot] = it.raw_sample;
        win_slot = (win_slot + 1) % AvgWin;
      end
      CMD_WRITE: begin
        gear_labels[it.entry_index] = it.entry_label;
        gear_raws[it.entry_index] = it.entry_raw;
      end
      CMD_CAPTURE: begin
        avg = SampleW'(win_sum / AvgWin);
        for (i = 0; i < gears_in_use; i++) begin
          if (!hit && gear_labels[i] == it.entry_label) begin
            gear_raws[i] = avg;
            hit = 1'b1;
          end
        end
      end
      default: begin
        // reserved command: state untouched, still one reading
      end
    endcase
    avg = SampleW'(win_sum / AvgWin);
    res.average = avg;
    res.gear = NoGear;
    best_dist = 32'hFFFF_FFFF;
    // First entry at the smallest distance wins
    for (i = 0; i < gears_in_use; i++) begin
      diff = 32'((avg > gear_raws[i]) ? avg - gear_raws[i] : gear_raws[i] - avg);
      if (diff < best_dist) begin
        best_dist = diff;
        res.gear = gear_labels[i];
      end
    end
    if (gears_in_use == 0 || best_dist > tolerance) res.gear = NoGear;
    return res;
  endfunction

  function automatic gear_item_t make_item(logic [CmdW-1:0] cmd, int raw, int idx, int label,
                                           int eraw);
    gear_item_t it;
    it.cmd = cmd;
    it.raw_sample = SampleW'(raw);
    it.entry_index = IndexW'(idx);
    it.entry_label = LabelW'(label);
    it.entry_raw = SampleW'(eraw);
    return it;
  endfunction

  // Random traffic: mostly samples drifting around a target so that matches happen
  function automatic gear_item_t make_traffic_item();
    gear_item_t it;
    logic [63:0] noise;
    int roll;
    int val;
    noise = {$urandom, $urandom};
    it = noise[$bits(gear_item_t)-1:0];
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) begin
      case ($urandom_range(0, 3))
        0: drift_target = 0;
        1: drift_target = 65535;
        2: drift_target = $urandom_range(0, 65535);
        default: drift_target = int'(gear_raws[$urandom_range(0, TableDepth - 1)]);
      endcase
    end
    val = drift_target + $urandom_range(0, 80) - 40;
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    if (roll < 60) begin
      it.cmd = CMD_SAMPLE;
      it.raw_sample = SampleW'(val);
    end else if (roll < 72) begin
      it.cmd = CMD_WRITE;
      if ($urandom_range(0, 1) == 0) it.entry_label = LabelW'($urandom_range(0, 4) - 2);
      if ($urandom_range(0, 1) == 0) it.entry_raw = SampleW'(val);
    end else if (roll < 86) begin
      it.cmd = CMD_CAPTURE;
      if ($urandom_range(0, 1) == 0) begin
        it.entry_label = gear_labels[$urandom_range(0, TableDepth - 1)];
      end else begin
        it.entry_label = LabelW'($urandom_range(0, 4) - 2);
      end
    end else if (roll < 91) begin
      it.cmd = CmdReserved;
    end else begin
      it.cmd = CMD_SAMPLE;
    end
    return it;
  endfunction

  // Present one beat, hold it until taken, then maybe drop valid for a gap
  task automatic send_item(gear_item_t it);
    int gap;
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    raw_sample_i  <= it.raw_sample;
    entry_index_i <= it.entry_index;
    entry_label_i <= it.entry_label;
    entry_raw_i   <= it.entry_raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    readings_due.push_back(predict_gear(it));
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 100) : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until every reading due has come back
  task automatic settle_block();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup beat, access beat, then drop the select; mirror it in the predictor
  task automatic write_register(reg_idx_e idx, logic [DataW-1:0] value);
    int unsigned v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_GEAR_COUNT: begin
        v = 32'(value[CountW-1:0]);
        gears_in_use = (v > TableDepth) ? TableDepth : v;
      end
      default: tolerance = value[TolW-1:0];
    endcase
  endtask

  task automatic report_failure(string what, gear_reading_t want, gear_reading_t got);
    failure_count++;
    if (failure_count <= MaxReports) begin
      $display("%0t: %s: expected gear %0d avg %0d, got gear %0d avg %0d", $realtime, what,
               want.gear, want.average, got.gear, got.average);
    end
  endtask

  // Empty table: every reading is no gear, extremes of the window and a reserved command
  task automatic test_empty_table();
    send_item(make_item(CMD_SAMPLE, 65535, 0, 0, 0));
    send_item(make_item(CMD_SAMPLE, 0, 0, 0, 0));
    send_item(make_item(CmdReserved, 65535, 7, -1, 65535));
    send_item(make_item(CMD_CAPTURE, 0, 0, -128, 0));
  endtask

  // Load all slots, label extremes, a repeated label and two equal raw values
  task automatic test_table_load();
    send_item(make_item(CMD_WRITE, 0, 0, -128, 0));
    send_item(make_item(CMD_WRITE, 0, 1, 127, 65535));
    send_item(make_item(CMD_WRITE, 0, 2, 1, 8191));
    send_item(make_item(CMD_WRITE, 0, 3, 2, 8191));
    send_item(make_item(CMD_WRITE, 0, 4, -1, 8000));
    send_item(make_item(CMD_WRITE, 0, 5, 3, 9000));
    send_item(make_item(CMD_WRITE, 0, 6, 0, 20000));
    send_item(make_item(CMD_WRITE, 0, 7, 1, 30000));
  endtask

  // Saturated count, zero tolerance: a tie on an exact hit, then a near miss
  task automatic test_tie_and_tolerance();
    settle_block();
    write_register(REG_GEAR_COUNT, 32'd15);
    write_register(REG_MATCH_TOL, 32'd0);
    send_item(make_item(CmdReserved, 0, 0, 0, 0));
    send_item(make_item(CMD_SAMPLE, 300, 0, 0, 0));
  endtask

  // Capture into the first labelled entry, a label that is absent, one out of use
  task automatic test_capture();
    settle_block();
    write_register(REG_MATCH_TOL, 32'd65535);
    send_item(make_item(CMD_CAPTURE, 0, 0, 1, 0));
    send_item(make_item(CMD_CAPTURE, 0, 0, 100, 0));
    send_item(make_item(CMD_SAMPLE, 65535, 0, 0, 0));
    settle_block();
    write_register(REG_GEAR_COUNT, 32'd1);
    write_register(REG_MATCH_TOL, 32'd64);
    send_item(make_item(CMD_CAPTURE, 0, 0, 127, 0));
    send_item(make_item(CMD_SAMPLE, 0, 7, 127, 65535));
  endtask

  // Random traffic over several register settings, extremes first
  task automatic test_random_traffic();
    int phase;
    int n;
    logic [DataW-1:0] count_val;
    logic [DataW-1:0] tol_val;
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin count_val = 8; tol_val = 64; end
        1: begin count_val = 15; tol_val = 0; end
        2: begin count_val = 0; tol_val = 65535; end
        3: begin count_val = 1; tol_val = 255; end
        default: begin
          count_val = $urandom_range(0, 15);
          case ($urandom_range(0, 3))
            0: tol_val = 0;
            1: tol_val = 65535;
            2: tol_val = $urandom_range(0, 255);
            default: tol_val = $urandom_range(0, 65535);
          endcase
        end
      endcase
      settle_block();
      write_register(REG_GEAR_COUNT, count_val);
      write_register(REG_MATCH_TOL, tol_val);
      for (n = 0; n < PhaseItems; n++) send_item(make_traffic_item());
    end
  endtask

  // Receiver: stall on a changing mix of open, random and blocky patterns
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(20, 300);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= (stall_run % 32) < 12;
    endcase
  end

  // Compare every result beat with the oldest reading due
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_reading.gear = detected_gear_o;
      seen_reading.average = average_value_o;
      if (readings_due.size() == 0) begin
        report_failure("unexpected result", '0, seen_reading);
      end else begin
        due_reading = readings_due.pop_front();
        if (seen_reading.gear !== due_reading.gear
            || seen_reading.average !== due_reading.average) begin
          report_failure("mismatch", due_reading, seen_reading);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("gear_position_nearest_match verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Predictor after reset; table contents are never read before written
    for (int i = 0; i < AvgWin; i++) win_samples[i] = '0;
    for (int i = 0; i < TableDepth; i++) begin
      gear_labels[i] = '0;
      gear_raws[i] = '0;
    end
    win_sum = '0;
    win_slot = 0;
    gears_in_use = 0;
    tolerance = TolReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_table_load();
    test_tie_and_tolerance();
    test_capture();
    test_random_traffic();
    settle_block();
    repeat (TableDepth + 12) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("gear_position_nearest_match verification clean");
    end else begin
      $display("gear_position_nearest_match verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/gpnm_pkg.sv
src/gpnm_window.sv
src/gpnm_cell.sv
src/gear_position_nearest_match.sv
tb/sv/gear_position_nearest_match_test.sv
